// ----- rtl/core/stsp_pkg.sv -----
// Shared constants and types for the stock span unit.
// Used by the front end, the item queue, the stack engine and the top level.
package stsp_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int PRICE_BITS  = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SPAN_W      = 11;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // One classified item as handed from the front end to the stack engine.
    typedef struct packed {
        logic [PRICE_BITS-1:0] key;   // order-preserving unsigned form of the price
        logic [CNT_W-1:0]      pos;   // position within the series
        logic                  ovf;   // beyond the stack depth
        logic                  last;  // final item of the series
    } t_item;

endpackage

// ----- rtl/core/stsp_front.sv -----
// Front end of the stock span unit: takes input transfers, tracks the series
// position and classifies each item. Depends on stsp_pkg.
module stsp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [stsp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,
    output stsp_pkg::t_item                 o_item,
    output logic                            o_item_valid,
    input  logic                            i_item_ready
);

    logic [stsp_pkg::CNT_W-1:0] r_pos;
    logic [stsp_pkg::CNT_W-1:0] n_pos;
    logic                       accept;
    logic                       ovf;

    assign o_s_tready   = i_item_ready;
    assign o_item_valid = i_s_tvalid;
    assign accept       = i_s_tvalid & i_item_ready;
    assign ovf          = (r_pos >= stsp_pkg::CNT_W'(stsp_pkg::STACK_DEPTH));

    // Flipping the sign bit makes an unsigned compare order the prices as signed.
    always_comb begin
        o_item.key  = i_s_tdata[stsp_pkg::PRICE_BITS-1:0]
                      ^ {1'b1, {(stsp_pkg::PRICE_BITS-1){1'b0}}};
        o_item.pos  = r_pos;
        o_item.ovf  = ovf;
        o_item.last = i_s_tlast;
    end

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_s_tlast) begin
                n_pos = '0;
            end else if (!ovf) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- rtl/core/stsp_queue.sv -----
// Two-entry item queue that decouples the front end from the stack engine.
// Depends on stsp_pkg.
module stsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stsp_pkg::t_item i_item,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    output stsp_pkg::t_item o_item,
    output logic            o_rd_valid,
    input  logic            i_rd_ready
);

    stsp_pkg::t_item             r_mem [stsp_pkg::QUEUE_DEPTH];
    logic [stsp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [stsp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [stsp_pkg::QCNT_W-1:0] r_cnt;
    logic                        push;
    logic                        pop;

    assign o_wr_ready = (r_cnt != stsp_pkg::QCNT_W'(stsp_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign push       = i_wr_valid & o_wr_ready;
    assign pop        = o_rd_valid & i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/stsp_back.sv -----
// Stack engine of the stock span unit: pops dominated entries, computes the
// span, pushes the new entry and holds the result register. Depends on stsp_pkg.
module stsp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stsp_pkg::t_item                 i_item,
    input  logic                            i_item_valid,
    output logic                            o_item_ready,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [stsp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [0:0]                      o_m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    localparam int ENTRY_W = stsp_pkg::ADDR_W + stsp_pkg::PRICE_BITS;

    // Stack entries, the top included; the top itself is also cached in registers.
    logic [ENTRY_W-1:0] mem [stsp_pkg::STACK_DEPTH];

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [stsp_pkg::CNT_W-1:0]     r_count;
    logic [stsp_pkg::CNT_W-1:0]     n_count;
    stsp_pkg::t_item                r_cur;
    logic [stsp_pkg::PRICE_BITS-1:0] r_top_key;
    logic [stsp_pkg::ADDR_W-1:0]    r_top_pos;
    logic [ENTRY_W-1:0]             r_rd_data;
    logic                           r_out_valid;
    logic [stsp_pkg::SPAN_W-1:0]    r_span;
    logic                           r_ovf;

    logic                           out_free;
    logic                           take;
    logic                           do_push;
    logic                           rd_en;
    logic [stsp_pkg::ADDR_W-1:0]    rd_addr;
    logic                           emit;
    logic [stsp_pkg::SPAN_W-1:0]    n_span;
    logic [stsp_pkg::CNT_W-1:0]     count_m2;

    assign out_free     = !r_out_valid || i_m_tready;
    assign o_item_ready = (r_state == ST_IDLE);
    assign take         = i_item_valid && (r_state == ST_IDLE);
    assign count_m2     = r_count - stsp_pkg::CNT_W'(2);
    assign rd_addr      = count_m2[stsp_pkg::ADDR_W-1:0];

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        do_push = 1'b0;
        rd_en   = 1'b0;
        emit    = 1'b0;
        n_span  = '0;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_cur.ovf) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                        if (r_cur.last) begin
                            n_count = '0;
                        end
                    end
                end else if ((r_count != '0) && (r_top_key <= r_cur.key)) begin
                    n_count = r_count - 1'b1;
                    if (r_count > stsp_pkg::CNT_W'(1)) begin
                        rd_en   = 1'b1;
                        n_state = ST_LOAD;
                    end
                end else if (out_free) begin
                    emit    = 1'b1;
                    do_push = 1'b1;
                    n_state = ST_IDLE;
                    if (r_count == '0) begin
                        n_span = stsp_pkg::SPAN_W'(r_cur.pos + 1'b1);
                    end else begin
                        n_span = stsp_pkg::SPAN_W'(r_cur.pos
                                 - stsp_pkg::CNT_W'(r_top_pos));
                    end
                    n_count = r_cur.last ? '0 : r_count + 1'b1;
                end
            end
            ST_LOAD: begin
                n_state = ST_CMP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_count[stsp_pkg::ADDR_W-1:0]] <= {r_cur.pos[stsp_pkg::ADDR_W-1:0],
                                                   r_cur.key};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur <= i_item;
        end
        if (do_push) begin
            r_top_key <= r_cur.key;
            r_top_pos <= r_cur.pos[stsp_pkg::ADDR_W-1:0];
        end else if (r_state == ST_LOAD) begin
            r_top_key <= r_rd_data[stsp_pkg::PRICE_BITS-1:0];
            r_top_pos <= r_rd_data[ENTRY_W-1:stsp_pkg::PRICE_BITS];
        end
        if (emit) begin
            r_span <= n_span;
            r_ovf  <= r_cur.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(stsp_pkg::OUT_DATA_W-stsp_pkg::SPAN_W){1'b0}}, r_span};
    assign o_m_tuser  = r_ovf;

endmodule

// ----- rtl/core/stock_span_monotonic_stack_unit.sv -----
// Each input transfer enters the item queue; the stack engine takes an item only while
// idle, compares it with the cached top, reads the next entry from its one-port stack
// memory (registered read) via a load state after a pop that leaves one below, and
// registers the result once the output is free. Each entry is popped at most once; no
// new item is taken before the last is emitted. Reset: synchronous, active low on i_rst_n;
// clears position, stack count, queue and the result valid flag, but not the stack memory.
module stock_span_monotonic_stack_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [stsp_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [31:0] price (signed)
    input  logic                            i_s_tlast,   // last item of the series
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [stsp_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [10:0] span, [15:11] zero
    output logic [0:0]                      o_m_tuser    // [0] overflow
);

    // The front end stamps each item with its series position and decides overflow
    // there, so the stack engine never has to look back at the input side.
    stsp_pkg::t_item front_item;
    stsp_pkg::t_item back_item;
    logic            front_valid;
    logic            queue_wr_ready;
    logic            queue_rd_valid;
    logic            back_ready;

    stsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (queue_wr_ready)
    );

    // The two-entry queue lets the front end keep taking transfers while the stack engine
    // works through pops or waits for the result to be taken, until the queue is full.
    stsp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (front_item),
        .i_wr_valid (front_valid),
        .o_wr_ready (queue_wr_ready),
        .o_item     (back_item),
        .o_rd_valid (queue_rd_valid),
        .i_rd_ready (back_ready)
    );

    // The stack engine owns the stack and the result register.
    stsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (back_item),
        .i_item_valid (queue_rd_valid),
        .o_item_ready (back_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

// ----- rtl/core/stsp_checker.sv -----
// Port-level checks for the stock span unit, bound to the top level.
// Depends only on the top level's ports.
module stsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    a_ovf_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[10:0] == 11'd0)
        else $error("overflow result carries a nonzero span");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[10:0] != 11'd0)
        else $error("regular result has span zero");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:11] == 5'd0 && o_m_tdata[10:0] <= 11'd1024)
        else $error("span out of range or padding bits set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind stock_span_monotonic_stack_unit stsp_checker u_stsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
